[hw/rtl/urb_pkg.sv]
// shared types and constants for the serial port ring buffer block
// no dependencies; imported by urb_front, urb_back and the top level
package urb_pkg;

   // ring sizes
   localparam int TX_DEPTH = 256;
   localparam int RX_DEPTH = 64;
   localparam int TX_AW    = $clog2(TX_DEPTH);
   localparam int RX_AW    = $clog2(RX_DEPTH);

   // field widths
   localparam int OP_W   = 2;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 6;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QA_W        = $clog2(QUEUE_DEPTH);
   localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

   // request op codes
   localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK = 2'd1;
   localparam logic [OP_W-1:0] OP_RECV = 2'd2;
   localparam logic [OP_W-1:0] OP_READ = 2'd3;

   // classified command kinds
   typedef enum logic [2:0] {
      K_PUT,
      K_TICK,
      K_RECV,
      K_RECV_BAD,
      K_READ
   } kind_type;

   // one queued command
   typedef struct packed {
      kind_type           kind;
      logic [BYTE_W-1:0]  data;
      logic [LEN_W-1:0]   max_len;
   } cmd_type;

   // head of the command queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

endpackage

[hw/rtl/urb_front.sv]
// front end: accepts request words, classifies them and queues them
// depends on urb_pkg
module urb_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [urb_pkg::OP_W-1:0]     req_op,
   input  logic [urb_pkg::BYTE_W-1:0]   req_data,
   input  logic                         req_rx_error,
   input  logic [urb_pkg::LEN_W-1:0]    req_max_len,
   output urb_pkg::qhead_type           head,
   input  logic                         pop
);
   import urb_pkg::*;

   cmd_type           q_mem_ff [QUEUE_DEPTH];
   logic [QA_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]   count_ff, count_in;
   logic              push;
   cmd_type           cmd_new;

   // classify the incoming word
   always_comb begin
      cmd_new.data    = req_data;
      cmd_new.max_len = req_max_len;
      case (req_op)
         OP_PUT:  cmd_new.kind = K_PUT;
         OP_TICK: cmd_new.kind = K_TICK;
         OP_RECV: cmd_new.kind = req_rx_error ? K_RECV_BAD : K_RECV;
         OP_READ: cmd_new.kind = K_READ;
         default: cmd_new.kind = K_TICK;
      endcase
   end

   assign busy = (count_ff == QC_W'(QUEUE_DEPTH));
   assign push = start && !busy;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_mem_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   // the back end never pops an empty queue
   assert property (@(posedge clock) disable iff (reset) pop |-> head.valid)
      else $error("pop from empty command queue");
   // a push without pop grows the fill count by one
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("command queue count lost a push");
   // fill count stays within the queue depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QC_W'(QUEUE_DEPTH))
      else $error("command queue overfilled");
`endif

endmodule

[hw/rtl/urb_back.sv]
// back end: sequencer that carries out queued commands on the two rings
// depends on urb_pkg; holds the transmit and receive ring memories
module urb_back (
   input  logic                         clock,
   input  logic                         reset,
   input  urb_pkg::qhead_type           head,
   output logic                         pop,
   input  logic                         csr_we,
   input  logic                         csr_data,
   output logic                         rsp_strobe,
   output logic                         rsp_tx_valid,
   output logic [urb_pkg::BYTE_W-1:0]   rsp_tx_byte,
   output logic                         rsp_rx_valid,
   output logic [urb_pkg::BYTE_W-1:0]   rsp_rx_byte,
   output logic                         rsp_last,
   output logic                         rsp_rx_dropped,
   output logic                         rsp_tx_busy_out
);
   import urb_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PUT,
      S_TICK,
      S_TICK_OUT,
      S_RECV,
      S_RD_SETUP,
      S_READ
   } state_type;

   localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
   localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

   state_type          state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   logic               tx_busy_ff, tx_busy_in;
   logic [TX_AW-1:0]   tx_rptr_ff, tx_rptr_in;
   logic [TX_AW-1:0]   tx_wptr_ff, tx_wptr_in;
   logic [RX_AW-1:0]   rx_rptr_ff, rx_rptr_in;
   logic [RX_AW-1:0]   rx_wptr_ff, rx_wptr_in;
   logic               rx_enable_ff;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic               pend_ff, pend_in;
   logic               pend_last_ff, pend_last_in;

   logic               strobe_ff, strobe_in;
   logic               txv_ff, txv_in;
   logic [BYTE_W-1:0]  txb_ff, txb_in;
   logic               rxv_ff, rxv_in;
   logic [BYTE_W-1:0]  rxb_ff, rxb_in;
   logic               last_ff, last_in;
   logic               drop_ff, drop_in;
   logic               busy_out_ff, busy_out_in;

   logic [BYTE_W-1:0]  tx_mem_ff [TX_DEPTH];
   logic [BYTE_W-1:0]  rx_mem_ff [RX_DEPTH];
   logic [BYTE_W-1:0]  tx_rd_ff;
   logic [BYTE_W-1:0]  rx_rd_ff;
   logic               tx_we;
   logic               rx_we;

   logic [TX_AW-1:0]   tx_wnext;
   logic [RX_AW-1:0]   rx_wnext;
   logic [RX_AW-1:0]   rx_rnext;
   logic [RX_AW:0]     rx_count;
   logic [RX_AW:0]     len_ext;
   logic [RX_AW:0]     take;

   // pointer arithmetic
   assign tx_wnext = tx_wptr_ff + 1'b1;
   assign rx_wnext = (rx_wptr_ff == RX_LAST) ? '0 : rx_wptr_ff + 1'b1;
   assign rx_rnext = (rx_rptr_ff == RX_LAST) ? '0 : rx_rptr_ff + 1'b1;
   assign rx_count = (rx_wptr_ff >= rx_rptr_ff)
                     ? {1'b0, rx_wptr_ff} - {1'b0, rx_rptr_ff}
                     : {1'b0, rx_wptr_ff} + (RX_AW+1)'(RX_DEPTH) - {1'b0, rx_rptr_ff};
   assign len_ext  = (RX_AW+1)'(cur_ff.max_len);
   assign take     = (len_ext < rx_count) ? len_ext : rx_count;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      tx_busy_in   = tx_busy_ff;
      tx_rptr_in   = tx_rptr_ff;
      tx_wptr_in   = tx_wptr_ff;
      rx_rptr_in   = rx_rptr_ff;
      rx_wptr_in   = rx_wptr_ff;
      remain_in    = remain_ff;
      pend_in      = 1'b0;
      pend_last_in = 1'b0;
      pop          = 1'b0;
      tx_we        = 1'b0;
      rx_we        = 1'b0;
      strobe_in    = 1'b0;
      txv_in       = 1'b0;
      txb_in       = '0;
      rxv_in       = 1'b0;
      rxb_in       = '0;
      last_in      = 1'b1;
      drop_in      = 1'b0;
      busy_out_in  = tx_busy_ff;

      // byte read in the previous cycle goes out now
      if (pend_ff) begin
         strobe_in = 1'b1;
         rxv_in    = 1'b1;
         rxb_in    = rx_rd_ff;
         last_in   = pend_last_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               cur_in = head.cmd;
               case (head.cmd.kind)
                  K_PUT:      state_in = S_PUT;
                  K_TICK:     state_in = S_TICK;
                  K_RECV:     state_in = S_RECV;
                  K_RECV_BAD: state_in = S_RECV;
                  K_READ:     state_in = S_RD_SETUP;
                  default:    state_in = S_IDLE;
               endcase
            end
         end

         // queue the byte, or send it at once when idle
         S_PUT: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            if (tx_busy_ff) begin
               tx_we = 1'b1;
               if (tx_wptr_ff == TX_LAST) begin
                  tx_wptr_in = (tx_rptr_ff == '0) ? TX_LAST : '0;
               end else if (tx_wnext != tx_rptr_ff) begin
                  tx_wptr_in = tx_wnext;
               end
            end else begin
               tx_busy_in  = 1'b1;
               busy_out_in = 1'b1;
               txv_in      = 1'b1;
               txb_in      = cur_ff.data;
            end
         end

         // empty tick: oldest byte is fetched, or the transmitter goes idle
         S_TICK: begin
            if (tx_busy_ff && (tx_rptr_ff != tx_wptr_ff)) begin
               state_in = S_TICK_OUT;
            end else begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
               if (tx_busy_ff) begin
                  tx_busy_in  = 1'b0;
                  busy_out_in = 1'b0;
                  tx_rptr_in  = '0;
                  tx_wptr_in  = '0;
               end
            end
         end

         S_TICK_OUT: begin
            strobe_in  = 1'b1;
            txv_in     = 1'b1;
            txb_in     = tx_rd_ff;
            tx_rptr_in = (tx_rptr_ff == TX_LAST) ? '0 : tx_rptr_ff + 1'b1;
            state_in   = S_IDLE;
         end

         // store a good received byte while receive is enabled, dropping the oldest on overflow
         S_RECV: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            if (rx_enable_ff && (cur_ff.kind == K_RECV)) begin
               rx_we      = 1'b1;
               rx_wptr_in = rx_wnext;
               if (rx_wnext == rx_rptr_ff) begin
                  rx_rptr_in = rx_rnext;
                  drop_in    = 1'b1;
               end
            end
         end

         S_RD_SETUP: begin
            remain_in = take[LEN_W-1:0];
            state_in  = (take == '0) ? S_IDLE : S_READ;
         end

         // one ring read per cycle, each byte registered before it is emitted
         S_READ: begin
            pend_in      = 1'b1;
            pend_last_in = (remain_ff == LEN_W'(1));
            rx_rptr_in   = rx_rnext;
            remain_in    = remain_ff - 1'b1;
            if (remain_ff == LEN_W'(1)) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tx_busy_ff   <= 1'b0;
         tx_rptr_ff   <= '0;
         tx_wptr_ff   <= '0;
         rx_rptr_ff   <= '0;
         rx_wptr_ff   <= '0;
         rx_enable_ff <= 1'b0;
         remain_ff    <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tx_busy_ff   <= tx_busy_in;
         tx_rptr_ff   <= tx_rptr_in;
         tx_wptr_ff   <= tx_wptr_in;
         rx_rptr_ff   <= rx_rptr_in;
         rx_wptr_ff   <= rx_wptr_in;
         if (csr_we) begin
            rx_enable_ff <= csr_data;
         end
         remain_ff    <= remain_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         strobe_ff    <= strobe_in;
      end
      cur_ff      <= cur_in;
      txv_ff      <= txv_in;
      txb_ff      <= txb_in;
      rxv_ff      <= rxv_in;
      rxb_ff      <= rxb_in;
      last_ff     <= last_in;
      drop_ff     <= drop_in;
      busy_out_ff <= busy_out_in;
   end

   // transmit ring memory
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem_ff[tx_wptr_ff] <= cur_ff.data;
      end
      tx_rd_ff <= tx_mem_ff[tx_rptr_ff];
   end

   // receive ring memory
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem_ff[rx_wptr_ff] <= cur_ff.data;
      end
      rx_rd_ff <= rx_mem_ff[rx_rptr_ff];
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_tx_valid    = txv_ff;
   assign rsp_tx_byte     = txb_ff;
   assign rsp_rx_valid    = rxv_ff;
   assign rsp_rx_byte     = rxb_ff;
   assign rsp_last        = last_ff;
   assign rsp_rx_dropped  = drop_ff;
   assign rsp_tx_busy_out = busy_out_ff;

`ifndef NO_ASSERTIONS
   // an idle transmitter always has cleared pointers
   assert property (@(posedge clock) disable iff (reset)
      !tx_busy_ff |-> (tx_rptr_ff == '0 && tx_wptr_ff == '0))
      else $error("idle transmitter with stale pointers");
   // a read burst comes out on consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rxv_ff && !last_ff) |=> (strobe_ff && rxv_ff))
      else $error("gap inside a read burst");
   // a ring byte never shares a word with transmit or drop flags
   assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rxv_ff) |-> (!txv_ff && !drop_ff))
      else $error("read word carries transmit or drop flags");
   // commands are only taken while the sequencer is free
   assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff != S_IDLE))
      else $error("popped command not started");
`endif

endmodule

[hw/rtl/uart_tx_rx_ring_buffers.sv]
// the back-end sequencer carries out one command at a time and a read strobes
// its bytes one a cycle; a 2-entry queue buffers requests meanwhile;
// results are never held off; synchronous reset empties both rings and idles
// the transmitter; top level, depends on urb_pkg, urb_front, urb_back
module uart_tx_rx_ring_buffers (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [urb_pkg::OP_W-1:0]     req_op,
   input  logic [urb_pkg::BYTE_W-1:0]   req_data,
   input  logic                         req_rx_error,
   input  logic [urb_pkg::LEN_W-1:0]    req_max_len,
   output logic                         rsp_strobe,
   output logic                         rsp_tx_valid,
   output logic [urb_pkg::BYTE_W-1:0]   rsp_tx_byte,
   output logic                         rsp_rx_valid,
   output logic [urb_pkg::BYTE_W-1:0]   rsp_rx_byte,
   output logic                         rsp_last,
   output logic                         rsp_rx_dropped,
   output logic                         rsp_tx_busy_out,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_data
);
   import urb_pkg::*;

   qhead_type head;
   logic      pop;

   // register writes are always taken
   assign csr_ready = 1'b1;

   urb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_data     (req_data),
      .req_rx_error (req_rx_error),
      .req_max_len  (req_max_len),
      .head         (head),
      .pop          (pop)
   );

   urb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .csr_we          (csr_valid & csr_ready),
      .csr_data        (csr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_rx_valid    (rsp_rx_valid),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_last        (rsp_last),
      .rsp_rx_dropped  (rsp_rx_dropped),
      .rsp_tx_busy_out (rsp_tx_busy_out)
   );

endmodule

[tb/tb.sv]
// self-checking bench for uart_tx_rx_ring_buffers: directed table, receive overflow
// and random traffic, checked by a cycle-free buffer predictor or the typed table rows
// depends on urb_pkg and the uart_tx_rx_ring_buffers rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import urb_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int GAP_PERCENT   = 9;

   // one result word as the block strobes it
   typedef struct packed {
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              rx_valid;
      logic [BYTE_W-1:0] rx_byte;
      logic              last;
      logic              rx_dropped;
      logic              tx_busy;
   } reply_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   // one row of the directed table
   typedef struct {
      row_kind_type      kind;
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] data;
      logic              rx_error;
      logic [LEN_W-1:0]  max_len;
      bit                typed;
      reply_type         want;
   } stim_row_type;

   localparam reply_type NO_REPLY = '0;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [OP_W-1:0]   req_op;
   logic [BYTE_W-1:0] req_data;
   logic              req_rx_error;
   logic [LEN_W-1:0]  req_max_len;
   logic              rsp_strobe;
   logic              rsp_tx_valid;
   logic [BYTE_W-1:0] rsp_tx_byte;
   logic              rsp_rx_valid;
   logic [BYTE_W-1:0] rsp_rx_byte;
   logic              rsp_last;
   logic              rsp_rx_dropped;
   logic              rsp_tx_busy_out;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_data;

   // predictor state: transmit ring, receive ring and the enable register
   bit                line_busy = 1'b0;
   int unsigned       txq_rd = 0;
   int unsigned       txq_wr = 0;
   logic [BYTE_W-1:0] txq_mem [TX_DEPTH];
   int unsigned       rxq_rd = 0;
   int unsigned       rxq_wr = 0;
   logic [BYTE_W-1:0] rxq_mem [RX_DEPTH];
   bit                rx_accept = 1'b0;

   reply_type    replies_due[$];
   stim_row_type dir_rows[$];
   bit           gaps_on;
   int unsigned  mismatches = 0;
   int unsigned  replies_seen = 0;
   int unsigned  words_sent = 0;

   uart_tx_rx_ring_buffers dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_data        (req_data),
      .req_rx_error    (req_rx_error),
      .req_max_len     (req_max_len),
      .rsp_strobe      (rsp_strobe),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_rx_valid    (rsp_rx_valid),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_last        (rsp_last),
      .rsp_rx_dropped  (rsp_rx_dropped),
      .rsp_tx_busy_out (rsp_tx_busy_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #1ms;
      $display("timeout: results still outstanding = %0d", replies_due.size());
      $display("uart_tx_rx_ring_buffers test failed");
      $finish;
   end

   function automatic reply_type reply_of(bit txv, bit [7:0] txb, bit rxv, bit [7:0] rxb,
                                          bit lst, bit drop, bit bsy);
      reply_type r;
      r.tx_valid   = txv;
      r.tx_byte    = txb;
      r.rx_valid   = rxv;
      r.rx_byte    = rxb;
      r.last       = lst;
      r.rx_dropped = drop;
      r.tx_busy    = bsy;
      return r;
   endfunction

   task automatic table_row(row_kind_type kind, logic [OP_W-1:0] op,
                            logic [BYTE_W-1:0] data, logic err, logic [LEN_W-1:0] len,
                            bit typed, reply_type want);
      stim_row_type row;
      row.kind     = kind;
      row.op       = op;
      row.data     = data;
      row.rx_error = err;
      row.max_len  = len;
      row.typed    = typed;
      row.want     = want;
      dir_rows.push_back(row);
   endtask

   // expected result words for one accepted word, state advanced in place
   task automatic predict_buffers(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                  logic rx_error, logic [LEN_W-1:0] max_len);
      int unsigned held;
      int unsigned n;
      reply_type   r;
      r      = '0;
      r.last = 1'b1;
      case (op)
         OP_PUT: begin
            if (line_busy) begin
               // queue it; a full ring keeps rewriting the newest slot
               txq_mem[txq_wr] = data;
               txq_wr++;
               if (txq_wr >= TX_DEPTH)
                  txq_wr = (txq_rd == 0) ? TX_DEPTH - 1 : 0;
               else if (txq_wr == txq_rd)
                  txq_wr--;
            end else begin
               line_busy  = 1'b1;
               r.tx_valid = 1'b1;
               r.tx_byte  = data;
            end
         end
         OP_TICK: begin
            if (line_busy) begin
               if (txq_rd == txq_wr) begin
                  line_busy = 1'b0;
                  txq_rd    = 0;
                  txq_wr    = 0;
               end else begin
                  r.tx_valid = 1'b1;
                  r.tx_byte  = txq_mem[txq_rd];
                  txq_rd     = (txq_rd + 1) % TX_DEPTH;
               end
            end
         end
         OP_RECV: begin
            if (rx_accept && !rx_error) begin
               // store, dropping the oldest byte on overflow
               rxq_mem[rxq_wr] = data;
               rxq_wr = (rxq_wr + 1) % RX_DEPTH;
               if (rxq_wr == rxq_rd) begin
                  rxq_rd       = (rxq_rd + 1) % RX_DEPTH;
                  r.rx_dropped = 1'b1;
               end
            end
         end
         default: begin
            // read out up to max_len bytes, oldest first
            held = (rxq_wr + RX_DEPTH - rxq_rd) % RX_DEPTH;
            n    = (max_len < held) ? max_len : held;
            for (int i = 0; i < n; i++) begin
               r          = '0;
               r.rx_valid = 1'b1;
               r.rx_byte  = rxq_mem[rxq_rd];
               r.last     = (i + 1 == n);
               r.tx_busy  = line_busy;
               rxq_rd     = (rxq_rd + 1) % RX_DEPTH;
               replies_due.push_back(r);
            end
         end
      endcase
      if (op != OP_READ) begin
         r.tx_busy = line_busy;
         replies_due.push_back(r);
      end
   endtask

   // drive one word and hold it until the block takes it
   task automatic send_word(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                            logic rx_error, logic [LEN_W-1:0] max_len);
      while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_op       <= op;
      req_data     <= data;
      req_rx_error <= rx_error;
      req_max_len  <= max_len;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_buffers(op, data, rx_error, max_len);
      words_sent++;
   endtask

   // random traffic, mostly well formed
   task automatic random_word;
      int unsigned      pick;
      int unsigned      len_pick;
      logic [OP_W-1:0]  op;
      logic [LEN_W-1:0] len;
      pick = $urandom_range(99);
      if (pick < 30)
         op = OP_PUT;
      else if (pick < 55)
         op = OP_TICK;
      else if (pick < 85)
         op = OP_RECV;
      else
         op = OP_READ;
      len_pick = $urandom_range(9);
      if (len_pick < 7)
         len = LEN_W'($urandom_range(8, 1));
      else if (len_pick < 9)
         len = LEN_W'($urandom_range(63, 0));
      else
         len = 6'd63;
      send_word(op, BYTE_W'($urandom_range(255, 0)), $urandom_range(9) == 0, len);
   endtask

   // wait for every expected word, then for anything still in flight
   task automatic drain;
      start <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rx_enable(logic value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      rx_accept = value;
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, int got, int wanted);
      if (got != wanted)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, wanted));
   endtask

   // result monitor
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_strobe) begin
         replies_seen++;
         if (replies_due.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = replies_due.pop_front();
            check_field("tx_valid", int'(rsp_tx_valid), int'(want.tx_valid));
            check_field("tx_byte", int'(rsp_tx_byte), int'(want.tx_byte));
            check_field("rx_valid", int'(rsp_rx_valid), int'(want.rx_valid));
            check_field("rx_byte", int'(rsp_rx_byte), int'(want.rx_byte));
            check_field("last", int'(rsp_last), int'(want.last));
            check_field("rx_dropped", int'(rsp_rx_dropped), int'(want.rx_dropped));
            check_field("tx_busy_out", int'(rsp_tx_busy_out), int'(want.tx_busy));
         end
      end
   end

   // stimulus
   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_op       = OP_PUT;
      req_data     = '0;
      req_rx_error = 1'b0;
      req_max_len  = '0;
      csr_valid    = 1'b0;
      csr_data     = 1'b0;
      gaps_on      = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table, receive disabled after reset
      table_row(ROW_WORD, OP_TICK, 8'h00, 1'b0, 6'd0,  1'b1, reply_of(0, 0, 0, 0, 1, 0, 0));
      table_row(ROW_WORD, OP_READ, 8'h00, 1'b0, 6'd63, 1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_RECV, 8'hFF, 1'b0, 6'd0,  1'b1, reply_of(0, 0, 0, 0, 1, 0, 0));
      table_row(ROW_WORD, OP_PUT,  8'hFF, 1'b0, 6'd0,  1'b1, reply_of(1, 8'hFF, 0, 0, 1, 0, 1));
      table_row(ROW_WORD, OP_PUT,  8'h00, 1'b0, 6'd0,  1'b1, reply_of(0, 0, 0, 0, 1, 0, 1));
      table_row(ROW_WORD, OP_PUT,  8'hA5, 1'b1, 6'd63, 1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_TICK, 8'h00, 1'b0, 6'd0,  1'b1, reply_of(1, 8'h00, 0, 0, 1, 0, 1));
      table_row(ROW_WORD, OP_TICK, 8'hFF, 1'b1, 6'd63, 1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_TICK, 8'h00, 1'b0, 6'd0,  1'b1, reply_of(0, 0, 0, 0, 1, 0, 0));
      // receive enabled from here
      table_row(ROW_CSR,  OP_PUT,  8'h01, 1'b0, 6'd0,  1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_RECV, 8'h00, 1'b1, 6'd0,  1'b1, reply_of(0, 0, 0, 0, 1, 0, 0));
      table_row(ROW_WORD, OP_RECV, 8'hFF, 1'b0, 6'd0,  1'b1, reply_of(0, 0, 0, 0, 1, 0, 0));
      table_row(ROW_WORD, OP_RECV, 8'h80, 1'b0, 6'd0,  1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_RECV, 8'h01, 1'b0, 6'd0,  1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_READ, 8'h00, 1'b0, 6'd0,  1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_READ, 8'h00, 1'b0, 6'd2,  1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_READ, 8'hFF, 1'b1, 6'd63, 1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_READ, 8'h00, 1'b0, 6'd63, 1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_PUT,  8'h5A, 1'b0, 6'd0,  1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_TICK, 8'h00, 1'b0, 6'd0,  1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_RECV, 8'h7E, 1'b1, 6'd0,  1'b0, NO_REPLY);
      table_row(ROW_WORD, OP_TICK, 8'h00, 1'b0, 6'd0,  1'b0, NO_REPLY);
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            write_rx_enable(dir_rows[i].data[0]);
         end else begin
            send_word(dir_rows[i].op, dir_rows[i].data, dir_rows[i].rx_error,
                      dir_rows[i].max_len);
            if (dir_rows[i].typed)
               replies_due[replies_due.size() - 1] = dir_rows[i].want;
         end
      end

      // receive ring overflow, then one full-length read and a read of up to five bytes
      repeat (66) send_word(OP_RECV, BYTE_W'($urandom_range(255, 0)), 1'b0,
                            LEN_W'($urandom_range(63, 0)));
      send_word(OP_READ, 8'h00, 1'b0, 6'd63);
      send_word(OP_READ, 8'h00, 1'b0, 6'd5);

      // random traffic over both register settings
      repeat (30) random_word();
      write_rx_enable(1'b0);
      repeat (20) random_word();
      write_rx_enable(1'b1);
      gaps_on = 1'b0;
      repeat (25) random_word();
      gaps_on = 1'b1;
      repeat (15) random_word();

      drain();
      $display("sent %0d words and checked %0d result words", words_sent, replies_seen);
      $display("covered receive overflow, full-length reads and rx_enable 0 and 1");
      if (mismatches == 0) begin
         $display("uart_tx_rx_ring_buffers test passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("uart_tx_rx_ring_buffers test failed");
      end
      $finish;
   end

endmodule
